// File: src/cst_pkg.sv
package cst_pkg;

    // Field and datapath widths.
    localparam int ANGLE_W   = 25;
    localparam int FRAC_BITS = 16;
    localparam int TICK_W    = 16;
    localparam int DUR_W     = 16;
    localparam int TDATA_W   = 32;

    // Serial divider: dividend and divisor widths, step counter width.
    localparam int DIV_NW  = 40;
    localparam int DIV_DW  = 20;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);

    // Serial multiplier: signed multiplicand, unsigned multiplier, product.
    localparam int MC_W   = 27;
    localparam int MP_W   = FRAC_BITS + 1;
    localparam int PROD_W = MC_W + MP_W;
    localparam int MUL_CW = $clog2(MP_W + 1);

    // Register indexes of the configuration port.
    localparam logic CFG_DURATION = 1'b0;
    localparam logic CFG_TARGET   = 1'b1;

    // Request kinds on the input channel.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Number of constant divisions done on a start word.
    localparam int NUM_SDIV = 6;

    typedef logic [2:0] sdiv_idx_t;

    // Divisor for each start division: offset 3/40, half 1/2, then the
    // coefficient magnitudes 1/24, 1/12, 3/16 and 3/32.
    function automatic logic [5:0] sdiv_den(input sdiv_idx_t k);
        logic [5:0] d;
        unique case (k)
            3'd0:    d = 6'd40;
            3'd1:    d = 6'd2;
            3'd2:    d = 6'd24;
            3'd3:    d = 6'd12;
            3'd4:    d = 6'd16;
            default: d = 6'd32;
        endcase
        return d;
    endfunction

    // True where the division takes three times the angle span.
    function automatic logic sdiv_times3(input sdiv_idx_t k);
        return (k == 3'd0) || (k == 3'd4) || (k == 3'd5);
    endfunction

endpackage

// File: src/cst_div_serial.sv
module cst_div_serial (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cst_pkg::DIV_NW-1:0] dividend,
    input  logic [cst_pkg::DIV_DW-1:0] divisor,
    output logic                      done,
    output logic [cst_pkg::DIV_NW-1:0] quotient
);
    import cst_pkg::*;

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top, quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/cst_mul_serial.sv
module cst_mul_serial (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [cst_pkg::MC_W-1:0]  mcand,
    input  logic        [cst_pkg::MP_W-1:0]  mplier,
    output logic                             done,
    output logic signed [cst_pkg::PROD_W-1:0] product
);
    import cst_pkg::*;

    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mc_reg;
    logic        [MP_W-1:0]   mp_reg;
    logic        [MUL_CW-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CW'(MP_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and add, one multiplier bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            mc_reg  <= PROD_W'(mcand);
            mp_reg  <= mplier;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: src/cubic_spline_trajectory_core.sv
// Channel  | Direction | Handshake          | Word
// s_       | in        | s_tvalid/s_tready  | tdata: start_angle; tuser: req_type
// m_       | out       | m_tvalid/m_tready  | tdata: setpoint_angle
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
// A start word runs six constant divisions on the serial divider.
// A tick word runs one divider pass, then six multiplier passes.
// A tick at or past the duration skips the divider and multiplier and goes straight to the finish state.
// Reset is synchronous and clears the trajectory state and the output register.
// A finished setpoint waits in the output register while the next word is taken.
module cubic_spline_trajectory_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cst_pkg::TDATA_W-1:0]     s_tdata,   // [24:0] start_angle
    input  logic                            s_tuser,   // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cst_pkg::TDATA_W-1:0]     m_tdata,   // [24:0] setpoint_angle
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [cst_pkg::ANGLE_W-1:0]     cfg_wdata
);
    import cst_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SDIV = 3'd1;
    localparam logic [2:0] ST_TDIV = 3'd2;
    localparam logic [2:0] ST_TMUL = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;

    // Configuration registers.
    logic        [DUR_W-1:0]   dur_cfg_reg;
    logic signed [ANGLE_W-1:0] tgt_cfg_reg;

    // Trajectory state.
    logic        [TICK_W-1:0]  elapsed_reg;
    logic        [DUR_W-1:0]   dur_reg;
    logic signed [ANGLE_W-1:0] tgt_reg;
    logic signed [ANGLE_W-1:0] s_reg;
    logic                      neg_reg;
    logic        [ANGLE_W-1:0] mag_reg;
    logic        [ANGLE_W-1:0] res_reg [NUM_SDIV];
    logic signed [MC_W-1:0]    knot1_reg, knot2_reg, knot3_reg;

    // Sequencing.
    sdiv_idx_t   idx_reg;
    logic        div_launch_reg;
    logic        mul_launch_reg;
    logic [1:0]  piece_reg;
    logic [DIV_NW-1:0] tdvd_reg;
    logic [DIV_DW-1:0] tden_reg;

    // Tick datapath registers.
    logic [MP_W-1:0]            t_reg, u_reg, w_reg;
    logic signed [PROD_W+1:0]   lin_reg, acc_reg;
    logic signed [MC_W-1:0]     inner_reg;
    logic signed [29:0]         y_reg;

    logic                m_valid_reg;
    logic [ANGLE_W-1:0]  m_data_reg;

    // Unit connections.
    logic [DIV_NW-1:0]        div_dvd, div_q;
    logic [DIV_DW-1:0]        div_den;
    logic                     div_done;
    logic signed [MC_W-1:0]   mul_mc;
    logic [MP_W-1:0]          mul_mp;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_p;

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Angle span of a new start word.
    logic signed [ANGLE_W:0] da;
    logic [ANGLE_W:0]        da_abs;
    assign da     = {tgt_cfg_reg[ANGLE_W-1], tgt_cfg_reg}
                  - {s_tdata[ANGLE_W-1], s_tdata[ANGLE_W-1:0]};
    assign da_abs = da[ANGLE_W] ? (~da + 1'b1) : da;

    // Piece choice and division operands for a tick.
    logic [19:0] t10, dx, d2, d3, d5, d8, tnum, tden;
    logic        past_end;
    logic [1:0]  piece;
    assign dx  = {4'd0, dur_reg};
    assign t10 = ({4'd0, elapsed_reg} << 3) + ({4'd0, elapsed_reg} << 1);
    assign d2  = dx << 1;
    assign d3  = d2 + dx;
    assign d5  = (dx << 2) + dx;
    assign d8  = dx << 3;
    assign past_end = elapsed_reg >= dur_reg;

    always_comb begin
        if (({4'd0, elapsed_reg} << 1) <= dx) begin
            if (t10 <= d2) begin
                piece = 2'd0; tnum = t10;      tden = d2;
            end else begin
                piece = 2'd1; tnum = t10 - d2; tden = d3;
            end
        end else if (t10 <= d8) begin
            piece = 2'd2; tnum = t10 - d5; tden = d3;
        end else begin
            piece = 2'd3; tnum = t10 - d8; tden = d2;
        end
    end

    // Divider operands: constant divisions on a start, the phase on a tick.
    logic [ANGLE_W+1:0] snum;
    logic [5:0]         sden;
    assign sden = sdiv_den(idx_reg);
    assign snum = sdiv_times3(idx_reg) ? ({2'd0, mag_reg} + {1'b0, mag_reg, 1'b0})
                                       : {2'd0, mag_reg};
    assign div_dvd = (state_reg == ST_SDIV)
                   ? DIV_NW'(snum) + DIV_NW'(sden >> 1) : tdvd_reg;
    assign div_den = (state_reg == ST_SDIV) ? DIV_DW'(sden) : tden_reg;

    cst_div_serial u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_launch_reg),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Knot values at the ends of the active piece.
    logic signed [MC_W-1:0] y0, y1, coef_a, coef_b;
    logic [ANGLE_W-1:0]     mag_a, mag_b;
    logic                   coef_neg;
    always_comb begin
        unique case (piece_reg)
            2'd0: begin
                y0 = MC_W'(s_reg);  y1 = knot1_reg;
                mag_a = res_reg[2]; mag_b = res_reg[3];
            end
            2'd1: begin
                y0 = knot1_reg;     y1 = knot2_reg;
                mag_a = res_reg[4]; mag_b = res_reg[5];
            end
            2'd2: begin
                y0 = knot2_reg;     y1 = knot3_reg;
                mag_a = res_reg[5]; mag_b = res_reg[4];
            end
            default: begin
                y0 = knot3_reg;     y1 = MC_W'(tgt_reg);
                mag_a = res_reg[3]; mag_b = res_reg[2];
            end
        endcase
    end
    assign coef_neg = (piece_reg[1] == 1'b0) ^ neg_reg;
    assign coef_a   = coef_neg ? -$signed({2'd0, mag_a}) : $signed({2'd0, mag_a});
    assign coef_b   = coef_neg ? -$signed({2'd0, mag_b}) : $signed({2'd0, mag_b});

    // Multiplier operands by step.
    always_comb begin
        unique case (idx_reg)
            3'd0:    begin mul_mc = $signed(MC_W'(t_reg)); mul_mp = u_reg; end
            3'd1:    begin mul_mc = y0;                    mul_mp = u_reg; end
            3'd2:    begin mul_mc = y1;                    mul_mp = t_reg; end
            3'd3:    begin mul_mc = coef_a;                mul_mp = u_reg; end
            3'd4:    begin mul_mc = coef_b;                mul_mp = t_reg; end
            default: begin mul_mc = inner_reg;             mul_mp = w_reg; end
        endcase
    end

    cst_mul_serial u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_launch_reg),
        .mcand   (mul_mc),
        .mplier  (mul_mp),
        .done    (mul_done),
        .product (mul_p)
    );

    // Sums with the fresh product and the half-unit rounding bias.
    logic signed [PROD_W+1:0] p_ext, acc_sum, lin_sum;
    localparam logic signed [PROD_W+1:0] HALF = (PROD_W+2)'(1) <<< (FRAC_BITS - 1);
    assign p_ext   = (PROD_W+2)'(mul_p);
    assign acc_sum = acc_reg + p_ext + HALF;
    assign lin_sum = lin_reg + p_ext + HALF;

    // Start-side offsets applied to the start angle and target.
    logic signed [MC_W-1:0] off_s, half_s, s_ext, g_ext;
    assign s_ext  = MC_W'(s_reg);
    assign g_ext  = MC_W'(tgt_reg);
    assign off_s  = neg_reg ? -$signed({2'd0, res_reg[0]}) : $signed({2'd0, res_reg[0]});
    assign half_s = neg_reg ? -$signed({2'd0, res_reg[1]}) : $signed({2'd0, res_reg[1]});

    // Clamp at the target, then saturate to the angle range.
    logic signed [29:0] g30, cl;
    logic [ANGLE_W-1:0] y_out;
    localparam logic signed [29:0] AMAX = 30'((1 << (ANGLE_W - 1)) - 1);
    localparam logic signed [29:0] AMIN = -30'(1 << (ANGLE_W - 1));
    always_comb begin
        g30 = 30'(tgt_reg);
        if (s_reg > tgt_reg) begin
            cl = (y_reg < g30) ? g30 : y_reg;
        end else begin
            cl = (y_reg > g30) ? g30 : y_reg;
        end
        if (cl > AMAX) begin
            y_out = AMAX[ANGLE_W-1:0];
        end else if (cl < AMIN) begin
            y_out = AMIN[ANGLE_W-1:0];
        end else begin
            y_out = cl[ANGLE_W-1:0];
        end
    end

    logic [MP_W-1:0] t_clamp;
    localparam logic [MP_W-1:0] ONE = MP_W'(1) << FRAC_BITS;
    assign t_clamp = (div_q > DIV_NW'(ONE)) ? ONE : div_q[MP_W-1:0];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_cfg_reg <= DUR_W'(1000);
            tgt_cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DURATION: dur_cfg_reg <= cfg_wdata[DUR_W-1:0];
                default:      tgt_cfg_reg <= cfg_wdata;
            endcase
        end
    end

    // Sequencer and trajectory state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            div_launch_reg <= 1'b0;
            mul_launch_reg <= 1'b0;
            elapsed_reg    <= '0;
            dur_reg        <= '0;
            tgt_reg        <= '0;
            s_reg          <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            knot1_reg      <= '0;
            knot2_reg      <= '0;
            knot3_reg      <= '0;
            for (int i = 0; i < NUM_SDIV; i++) begin
                res_reg[i] <= '0;
            end
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end else begin
            div_launch_reg <= 1'b0;
            mul_launch_reg <= 1'b0;
            // The finish state reloads the output register itself.
            if (m_tready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser == REQ_START) begin
                            s_reg          <= s_tdata[ANGLE_W-1:0];
                            tgt_reg        <= tgt_cfg_reg;
                            dur_reg        <= dur_cfg_reg;
                            neg_reg        <= da[ANGLE_W];
                            mag_reg        <= da_abs[ANGLE_W-1:0];
                            elapsed_reg    <= '0;
                            idx_reg        <= '0;
                            div_launch_reg <= 1'b1;
                            state_reg      <= ST_SDIV;
                        end else if (past_end) begin
                            y_reg     <= 30'(tgt_reg);
                            state_reg <= ST_FIN;
                        end else begin
                            piece_reg      <= piece;
                            tdvd_reg       <= (DIV_NW'(tnum) << FRAC_BITS)
                                            + DIV_NW'(tden >> 1);
                            tden_reg       <= tden;
                            div_launch_reg <= 1'b1;
                            state_reg      <= ST_TDIV;
                        end
                    end
                end
                ST_SDIV: begin
                    if (div_done) begin
                        res_reg[idx_reg] <= div_q[ANGLE_W-1:0];
                        if (idx_reg == sdiv_idx_t'(NUM_SDIV - 1)) begin
                            knot1_reg <= s_ext + off_s;
                            knot2_reg <= s_ext + half_s;
                            knot3_reg <= g_ext - off_s;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg        <= idx_reg + 1'b1;
                            div_launch_reg <= 1'b1;
                        end
                    end
                end
                ST_TDIV: begin
                    if (div_done) begin
                        t_reg          <= t_clamp;
                        u_reg          <= ONE - t_clamp;
                        idx_reg        <= '0;
                        mul_launch_reg <= 1'b1;
                        state_reg      <= ST_TMUL;
                    end
                end
                ST_TMUL: begin
                    if (mul_done) begin
                        unique case (idx_reg)
                            3'd0:    w_reg     <= mul_p[FRAC_BITS +: MP_W];
                            3'd1:    lin_reg   <= p_ext;
                            3'd2:    lin_reg   <= lin_reg + p_ext;
                            3'd3:    acc_reg   <= p_ext;
                            3'd4:    inner_reg <= acc_sum[FRAC_BITS +: MC_W];
                            default: y_reg     <= lin_sum[FRAC_BITS +: 30];
                        endcase
                        if (idx_reg == 3'd5) begin
                            state_reg <= ST_FIN;
                        end else begin
                            idx_reg        <= idx_reg + 1'b1;
                            mul_launch_reg <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    // Hand the setpoint over once the output register is free.
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= y_out;
                        m_valid_reg <= 1'b1;
                        if (elapsed_reg != {TICK_W{1'b1}}) begin
                            elapsed_reg <= elapsed_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - ANGLE_W){1'b0}}, m_data_reg};

endmodule

// File: tb/cubic_spline_trajectory_checker.sv
module cubic_spline_trajectory_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [cst_pkg::TDATA_W-1:0]     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [cst_pkg::TDATA_W-1:0]     m_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [cst_pkg::ANGLE_W-1:0]     cfg_wdata,
    output int                              fail_count,
    output int                              pending_setpoints
);
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    // Register shadows and latched trajectory state.
    logic [DUR_W-1:0]   dur_reg;
    logic [ANGLE_W-1:0] target_reg;
    longint unsigned    tick_count;
    longint             knots[5];
    longint             shape[8];
    longint unsigned    traj_dur;

    logic [ANGLE_W-1:0] setpoint_q[$];

    const longint shape_num[8] = '{-1, -1, -3, -3, 3, 3, 1, 1};
    const longint shape_den[8] = '{24, 12, 16, 32, 32, 16, 12, 24};

    function automatic longint sext25(input logic [ANGLE_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    // Divide rounding to nearest, ties away from zero.
    function automatic longint round_div(input longint v, input longint d);
        if (v >= 0) begin
            return (v + d / 2) / d;
        end
        return -((-v + d / 2) / d);
    endfunction

    // Arithmetic right shift with round half up.
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Evaluate the spline piece for the current counter and clamp.
    function automatic logic [ANGLE_W-1:0] next_setpoint();
        longint unsigned num, den, t, u, w, tc, d;
        longint y, lin, inner;
        int p;
        tc = tick_count;
        d = traj_dur;
        if (tc >= d) begin
            y = knots[4];
        end else begin
            if (2 * tc <= d) begin
                if (10 * tc <= 2 * d) begin
                    p = 0; num = 10 * tc; den = 2 * d;
                end else begin
                    p = 1; num = 10 * tc - 2 * d; den = 3 * d;
                end
            end else if (10 * tc <= 8 * d) begin
                p = 2; num = 10 * tc - 5 * d; den = 3 * d;
            end else begin
                p = 3; num = 10 * tc - 8 * d; den = 2 * d;
            end
            t = ((num << FRAC_BITS) + den / 2) / den;
            if (t > (64'd1 << FRAC_BITS)) t = 64'd1 << FRAC_BITS;
            u = (64'd1 << FRAC_BITS) - t;
            w = (t * u) >> FRAC_BITS;
            lin = longint'(u) * knots[p] + longint'(t) * knots[p + 1];
            inner = round_shr(shape[2 * p] * longint'(u) + shape[2 * p + 1] * longint'(t),
                              FRAC_BITS);
            y = round_shr(lin + inner * longint'(w), FRAC_BITS);
        end
        if (knots[0] > knots[4]) begin
            if (y < knots[4]) y = knots[4];
        end else if (y > knots[4]) begin
            y = knots[4];
        end
        if (y > (longint'(1) << (ANGLE_W - 1)) - 1) y = (longint'(1) << (ANGLE_W - 1)) - 1;
        if (y < -(longint'(1) << (ANGLE_W - 1))) y = -(longint'(1) << (ANGLE_W - 1));
        return y[ANGLE_W-1:0];
    endfunction

    // Track config writes, predict on accepted input words, check output words.
    always @(posedge aclk) begin
        longint s, g, da, off;
        logic [ANGLE_W-1:0] want, got;
        if (!aresetn) begin
            dur_reg = 16'd1000;
            target_reg = '0;
            tick_count = 0;
            traj_dur = 0;
            for (int i = 0; i < 5; i++) knots[i] = 0;
            for (int i = 0; i < 8; i++) shape[i] = 0;
            setpoint_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[ANGLE_W-1:0];
                if (setpoint_q.size() == 0) begin
                    $display("%0t: unexpected setpoint word, expected none, actual %0d",
                             $time, sext25(got));
                    fail_count++;
                end else begin
                    want = setpoint_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: setpoint mismatch, expected %0d, actual %0d",
                                 $time, sext25(want), sext25(got));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_START) begin
                    s = sext25(s_tdata[ANGLE_W-1:0]);
                    g = sext25(target_reg);
                    da = g - s;
                    off = round_div(3 * da, 40);
                    knots[0] = s;
                    knots[1] = s + off;
                    knots[2] = s + round_div(da, 2);
                    knots[3] = g - off;
                    knots[4] = g;
                    for (int i = 0; i < 8; i++) shape[i] = round_div(da * shape_num[i], shape_den[i]);
                    traj_dur = dur_reg;
                    tick_count = 0;
                end else begin
                    setpoint_q.push_back(next_setpoint());
                    if (tick_count < 65535) tick_count++;
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_DURATION) dur_reg = cfg_wdata[DUR_W-1:0];
                else target_reg = cfg_wdata;
            end
        end
        pending_setpoints = setpoint_q.size();
    end

endmodule

// File: tb/cubic_spline_trajectory_core_test.sv
module cubic_spline_trajectory_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int ANGLE_MAX = 11796480;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [ANGLE_W-1:0]     cfg_wdata;
    int                     fail_count;
    int                     pending_setpoints;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    longint                 cycle_count;

    cubic_spline_trajectory_core u_top (.*);

    cubic_spline_trajectory_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Cycle limit guards against a hung handshake.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: random stalls at the configured rate.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One register write; the write enable then drops before the task returns.
    task automatic write_reg(input logic idx, input logic [ANGLE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Send one word, idling first per the sender rate; valid stays up afterwards
    // until the next word or the next drain replaces it.
    task automatic send_word(input logic kind, input logic [ANGLE_W-1:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(TDATA_W - ANGLE_W){1'b0}}, angle};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Wait for all setpoints and let a pending start word finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_setpoints != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    function automatic logic [ANGLE_W-1:0] rand_angle();
        int r;
        r = $urandom_range(9);
        if (r == 0) return ANGLE_W'(ANGLE_MAX);
        if (r == 1) return ANGLE_W'(-ANGLE_MAX);
        return ANGLE_W'(int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
    endfunction

    // One trajectory: new duration and target settings, a start, then a run of ticks.
    task automatic run_trajectory(input int dur, input int ticks);
        drain();
        write_reg(CFG_DURATION, ANGLE_W'(dur));
        write_reg(CFG_TARGET, rand_angle());
        send_word(REQ_START, rand_angle());
        for (int i = 0; i < ticks; i++) begin
            send_word(REQ_TICK, ANGLE_W'($urandom));
        end
    endtask

    initial begin
        int sent;
        int dur;
        int ticks;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = REQ_TICK;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_DURATION;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: ticks before any start give zero.
        send_word(REQ_TICK, '0);
        send_word(REQ_TICK, '1);
        drain();
        // Extreme angles, zero duration, one, two, and change mid-run.
        write_reg(CFG_DURATION, ANGLE_W'(0));
        write_reg(CFG_TARGET, ANGLE_W'(ANGLE_MAX));
        send_word(REQ_START, ANGLE_W'(-ANGLE_MAX));
        send_word(REQ_TICK, '0);
        drain();
        write_reg(CFG_DURATION, ANGLE_W'(1));
        send_word(REQ_START, ANGLE_W'(ANGLE_MAX));
        send_word(REQ_TICK, '0);
        send_word(REQ_TICK, '0);
        drain();
        write_reg(CFG_DURATION, ANGLE_W'(2));
        write_reg(CFG_TARGET, ANGLE_W'(-ANGLE_MAX));
        send_word(REQ_START, ANGLE_W'(ANGLE_MAX));
        for (int i = 0; i < 3; i++) send_word(REQ_TICK, '0);
        drain();
        write_reg(CFG_DURATION, ANGLE_W'(10));
        write_reg(CFG_TARGET, ANGLE_W'(ANGLE_MAX));
        send_word(REQ_START, ANGLE_W'(-ANGLE_MAX));
        for (int i = 0; i < 6; i++) send_word(REQ_TICK, '1);
        drain();
        write_reg(CFG_TARGET, ANGLE_W'(0));
        for (int i = 0; i < 6; i++) send_word(REQ_TICK, '0);
        drain();

        // Maximal duration.
        write_reg(CFG_DURATION, ANGLE_W'(65535));
        send_word(REQ_START, ANGLE_W'(ANGLE_MAX));
        for (int i = 0; i < 3; i++) send_word(REQ_TICK, '0);

        // Random trajectories through the idling phases.
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            while (sent < (ph + 1) * 105) begin
                dur = ($urandom_range(9) == 0) ? $urandom_range(65535, 2) : $urandom_range(30, 2);
                ticks = $urandom_range(dur + 3, 1) % 40 + 1;
                run_trajectory(dur, ticks);
                sent += ticks + 1;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: cubic_spline_trajectory_core.f
src/cst_pkg.sv
src/cst_div_serial.sv
src/cst_mul_serial.sv
src/cubic_spline_trajectory_core.sv
tb/cubic_spline_trajectory_checker.sv
tb/cubic_spline_trajectory_core_test.sv
